// File: rtl/core/bitmap_font_binary_parser_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef BITMAP_FONT_BINARY_PARSER_MACROS_SVH
`define BITMAP_FONT_BINARY_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define BMFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bmfp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BMFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bmfp assertion failed");

`else

`define BMFP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BMFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/bmfp_pkg.sv
package bmfp_pkg;

	// Kind of record carried by one output transaction.
	typedef enum logic [1:0] {
		KIND_GLYPH  = 2'd0,
		KIND_COMMON = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	// Final status codes.
	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_BAD_SIG       = 3'd1,
		ST_UNKNOWN_BLOCK = 3'd2,
		ST_TRUNCATED     = 3'd3,
		ST_TOO_MANY_PAGE = 3'd4,
		ST_UNTERMINATED  = 3'd5
	} status_t;

	// Block ids of the file format.
	localparam logic [7:0] BLK_INFO   = 8'd1;
	localparam logic [7:0] BLK_COMMON = 8'd2;
	localparam logic [7:0] BLK_PAGES  = 8'd3;
	localparam logic [7:0] BLK_CHARS  = 8'd4;
	localparam logic [7:0] BLK_KERN   = 8'd5;

	// File signature "BMF" followed by format version 3.
	localparam logic [7:0] SIG_BYTES [4] = '{8'h42, 8'h4D, 8'h46, 8'h03};

	// Record geometry.
	localparam int COMMON_LEN = 10;
	localparam int CHAR_LEN   = 20;
	localparam int STORE_LEN  = 18;

	// One result record as queued for the output channel.
	typedef struct packed {
		kind_t              kind;
		logic [7:0]         char_code;
		logic [15:0]        x_or_line_height;
		logic [15:0]        y_or_base;
		logic [15:0]        width_or_scale_w;
		logic [15:0]        height_or_scale_h;
		logic signed [15:0] x_offset;
		logic signed [15:0] y_offset;
		logic signed [15:0] advance;
		logic [15:0]        page_count;
		status_t            status;
		logic               last_result;
	} result_t;

endpackage

// File: rtl/core/bmfp_out_fifo.sv
module bmfp_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_cnt,
	input  bmfp_pkg::result_t push_data [2],
	input  logic              pop,
	output bmfp_pkg::result_t head,
	output logic [2:0]        level
);
	import bmfp_pkg::*;

	localparam int DEPTH = 4;

	result_t    mem_q [DEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] level_q;

	// Up to two entries are written per cycle, in order, at the write pointer.
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push_data[0];
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_q + 2'd1] <= push_data[1];
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_cnt;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			level_q  <= level_q + {1'b0, push_cnt} - {2'b00, pop};
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign level = level_q;

endmodule

// File: rtl/core/bitmap_font_binary_parser.sv
// Streaming parser for version 3 bitmap-font binary files. The file enters one byte per
// transaction on the input channel, with last_byte set on its final byte. Each byte is
// held in an input register and parsed in a single pass, so the block takes one byte per
// clock while the input is not stalled; results are queued straight from the input register.
// A byte yields at most two results: a glyph or common-info record, and on the
// final byte the status record. Results wait in a four-entry output queue; the input
// stalls only while that queue holds more than two results, so with the output taken
// every cycle the rate stays at one byte per clock. After the status record all state
// is back at reset and the next file may follow at once.
`include "bitmap_font_binary_parser_macros.svh"

module bitmap_font_binary_parser #(
	parameter int CHAR_CODE_LIMIT = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         record_kind,
	output logic [7:0]         char_code,
	output logic [15:0]        x_or_line_height,
	output logic [15:0]        y_or_base,
	output logic [15:0]        width_or_scale_w,
	output logic [15:0]        height_or_scale_h,
	output logic signed [15:0] x_offset,
	output logic signed [15:0] y_offset,
	output logic signed [15:0] advance,
	output logic [15:0]        page_count,
	output logic [2:0]         status,
	output logic               last_result
);
	import bmfp_pkg::*;

	localparam logic [32:0] CODE_LIMIT = 33'(CHAR_CODE_LIMIT);

	typedef enum logic [1:0] {
		PH_SIG,
		PH_HDR,
		PH_BODY,
		PH_ERR
	} phase_t;

	// Input register.
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       adv;

	// Parser state.
	phase_t      phase_q, phase_n;
	logic [2:0]  hdr_cnt_q, hdr_cnt_n;
	logic [7:0]  blk_id_q, blk_id_n;
	logic [31:0] remain_q, remain_n;
	logic [4:0]  offset_q, offset_n;
	logic [7:0]  rec_q [STORE_LEN];
	logic        name_pend_q, name_pend_n;
	status_t     err_q, err_n;
	logic        rec_wr;

	// Results of the current byte.
	logic        rec_valid;
	result_t     rec;
	result_t     stat;
	status_t     final_st;
	logic [31:0] glyph_code;
	logic [15:0] pages;
	logic [1:0]  push_cnt;
	result_t     push_data [2];
	result_t     head;
	logic [2:0]  fifo_level;

	// The held byte moves on when the queue has room for two results.
	assign adv      = valid_s1 && (fifo_level <= 3'd2);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	assign glyph_code = {rec_q[3], rec_q[2], rec_q[1], rec_q[0]};
	assign pages      = {data_s1, rec_q[8]};

	// Next state and record for the held byte.
	always_comb begin
		phase_n     = phase_q;
		hdr_cnt_n   = hdr_cnt_q;
		blk_id_n    = blk_id_q;
		remain_n    = remain_q;
		offset_n    = offset_q;
		err_n       = err_q;
		rec_wr      = 1'b0;
		rec_valid   = 1'b0;
		rec         = '0;
		name_pend_n = (data_s1 == 8'd0) ? 1'b0 : name_pend_q;

		unique case (phase_q)
			PH_SIG: begin
				if (data_s1 != SIG_BYTES[hdr_cnt_q[1:0]]) begin
					err_n   = ST_BAD_SIG;
					phase_n = PH_ERR;
				end else if (hdr_cnt_q == 3'd3) begin
					hdr_cnt_n = '0;
					phase_n   = PH_HDR;
				end else begin
					hdr_cnt_n = hdr_cnt_q + 3'd1;
				end
			end
			PH_HDR: begin
				// Id byte, then the body size in little-endian order.
				case (hdr_cnt_q)
					3'd0: begin
						blk_id_n = data_s1;
						remain_n = '0;
					end
					3'd1: remain_n[7:0]   = data_s1;
					3'd2: remain_n[15:8]  = data_s1;
					3'd3: remain_n[23:16] = data_s1;
					default: remain_n[31:24] = data_s1;
				endcase
				hdr_cnt_n = hdr_cnt_q + 3'd1;
				if (hdr_cnt_q == 3'd4) begin
					hdr_cnt_n = '0;
					offset_n  = '0;
					if (blk_id_q < BLK_INFO || blk_id_q > BLK_KERN) begin
						err_n = ST_UNKNOWN_BLOCK;
					end
					if (blk_id_q == BLK_PAGES) begin
						name_pend_n = 1'b1;
					end
					if (remain_n == 32'd0) begin
						phase_n = (err_n != ST_OK) ? PH_ERR : PH_HDR;
					end else begin
						phase_n = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				remain_n = remain_q - 32'd1;
				if (blk_id_q == BLK_COMMON && offset_q < 5'(COMMON_LEN)) begin
					rec_wr   = 1'b1;
					offset_n = offset_q + 5'd1;
					if (offset_q == 5'(COMMON_LEN - 1)) begin
						// The page count's high byte is the byte in hand.
						rec_valid             = 1'b1;
						rec.kind              = KIND_COMMON;
						rec.x_or_line_height  = {rec_q[1], rec_q[0]};
						rec.y_or_base         = {rec_q[3], rec_q[2]};
						rec.width_or_scale_w  = {rec_q[5], rec_q[4]};
						rec.height_or_scale_h = {rec_q[7], rec_q[6]};
						rec.page_count        = pages;
						if (pages > 16'd1 && err_q == ST_OK) begin
							err_n = ST_TOO_MANY_PAGE;
						end
					end
				end else if (blk_id_q == BLK_CHARS) begin
					rec_wr   = offset_q < 5'(STORE_LEN);
					offset_n = offset_q + 5'd1;
					if (offset_q >= 5'(CHAR_LEN - 1)) begin
						offset_n = '0;
						if ({1'b0, glyph_code} < CODE_LIMIT) begin
							rec_valid             = 1'b1;
							rec.kind              = KIND_GLYPH;
							rec.char_code         = glyph_code[7:0];
							rec.x_or_line_height  = {rec_q[5], rec_q[4]};
							rec.y_or_base         = {rec_q[7], rec_q[6]};
							rec.width_or_scale_w  = {rec_q[9], rec_q[8]};
							rec.height_or_scale_h = {rec_q[11], rec_q[10]};
							rec.x_offset          = {rec_q[13], rec_q[12]};
							rec.y_offset          = {rec_q[15], rec_q[14]};
							rec.advance           = {rec_q[17], rec_q[16]};
						end
					end
				end
				if (remain_n == 32'd0) begin
					phase_n   = (err_n != ST_OK) ? PH_ERR : PH_HDR;
					hdr_cnt_n = (err_n != ST_OK) ? hdr_cnt_n : 3'd0;
				end
			end
			default: begin
			end
		endcase
		rec.last_result = !last_s1;
	end

	// Final status from the state that the last byte leaves.
	always_comb begin
		unique case (phase_n)
			PH_SIG:  final_st = ST_BAD_SIG;
			PH_ERR:  final_st = name_pend_n ? ST_UNTERMINATED : err_n;
			PH_HDR:  final_st = name_pend_n ? ST_UNTERMINATED : ST_OK;
			default: begin
				if (blk_id_n == BLK_PAGES) begin
					final_st = ST_TRUNCATED;
				end else begin
					final_st = name_pend_n ? ST_UNTERMINATED : ST_TRUNCATED;
				end
			end
		endcase
		stat             = '0;
		stat.kind        = KIND_STATUS;
		stat.status      = final_st;
		stat.last_result = 1'b1;
	end

	// Pack the results of this byte, record first, into the queue.
	always_comb begin
		push_data[0] = rec_valid ? rec : stat;
		push_data[1] = stat;
		if (!adv) begin
			push_cnt = 2'd0;
		end else begin
			push_cnt = {1'b0, rec_valid} + {1'b0, last_s1};
		end
	end

	// Parser state register; the final byte returns everything to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIG;
			hdr_cnt_q   <= '0;
			blk_id_q    <= '0;
			remain_q    <= '0;
			offset_q    <= '0;
			name_pend_q <= 1'b0;
			err_q       <= ST_OK;
		end else if (adv) begin
			if (last_s1) begin
				phase_q     <= PH_SIG;
				hdr_cnt_q   <= '0;
				blk_id_q    <= '0;
				remain_q    <= '0;
				offset_q    <= '0;
				name_pend_q <= 1'b0;
				err_q       <= ST_OK;
			end else begin
				phase_q     <= phase_n;
				hdr_cnt_q   <= hdr_cnt_n;
				blk_id_q    <= blk_id_n;
				remain_q    <= remain_n;
				offset_q    <= offset_n;
				name_pend_q <= name_pend_n;
				err_q       <= err_n;
			end
		end
	end

	// Record byte store, written at the running offset.
	always_ff @(posedge clk) begin
		if (adv && rec_wr) begin
			rec_q[offset_q] <= data_s1;
		end
	end

	bmfp_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push_data (push_data),
		.pop       (out_valid && !out_stall),
		.head      (head),
		.level     (fifo_level)
	);

	// Output channel driven from the queue head.
	assign out_valid         = fifo_level != 3'd0;
	assign record_kind       = head.kind;
	assign char_code         = head.char_code;
	assign x_or_line_height  = head.x_or_line_height;
	assign y_or_base         = head.y_or_base;
	assign width_or_scale_w  = head.width_or_scale_w;
	assign height_or_scale_h = head.height_or_scale_h;
	assign x_offset          = head.x_offset;
	assign y_offset          = head.y_offset;
	assign advance           = head.advance;
	assign page_count        = head.page_count;
	assign status            = head.status;
	assign last_result       = head.last_result;

	// Checks on flow control and end-of-file handling.
	`BMFP_ASSERT_SAME(a_level_bound, clk, arst_n, 1'b1, fifo_level <= 3'd4)
	`BMFP_ASSERT_SAME(a_stall_held, clk, arst_n, in_stall, valid_s1)
	`BMFP_ASSERT_SAME(a_two_needs_last, clk, arst_n, push_cnt == 2'd2, last_s1)
	`BMFP_ASSERT_NEXT(a_eof_reset, clk, arst_n, adv && last_s1, phase_q == PH_SIG)

endmodule

// File: dv/tb_top.sv
module tb_top;
	import bmfp_pkg::*;

	localparam int unsigned CODE_LIMIT = 256;

	// Parser stages of the byte-level model.
	typedef enum logic [1:0] {
		STG_SIGNATURE,
		STG_HEADER,
		STG_BODY,
		STG_HALTED
	} stage_t;

	// One byte waiting to be offered, with the idle cycles that come before it.
	typedef struct {
		logic [7:0] data;
		logic       fin;
		int         gap;
		bit         drain;
	} byte_item_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         data_byte = 8'd0;
	logic               last_byte = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         record_kind;
	logic [7:0]         char_code;
	logic [15:0]        x_or_line_height;
	logic [15:0]        y_or_base;
	logic [15:0]        width_or_scale_w;
	logic [15:0]        height_or_scale_h;
	logic signed [15:0] x_offset;
	logic signed [15:0] y_offset;
	logic signed [15:0] advance;
	logic [15:0]        page_count;
	logic [2:0]         status;
	logic               last_result;

	byte_item_t pending_bytes[$];
	result_t    expected_records[$];
	logic [7:0] file_buf[$];
	bit         failed = 1'b0;

	// State of the byte-level parser model.
	stage_t     stg;
	logic [2:0] hdr_cnt;
	logic [7:0] blk_id;
	logic [31:0] blk_left;
	logic [4:0] rec_off;
	logic [7:0] rec_buf [STORE_LEN];
	logic       name_open;
	status_t    err_code;

	int idle_count;
	int stall_count;
	int hold_count;
	int results_checked;

	bitmap_font_binary_parser #(.CHAR_CODE_LIMIT(CODE_LIMIT)) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] le16(input int at);
		return {rec_buf[at + 1], rec_buf[at]};
	endfunction

	task automatic clear_parser_model();
		stg = STG_SIGNATURE;
		hdr_cnt = 3'd0;
		blk_id = 8'd0;
		blk_left = 32'd0;
		rec_off = 5'd0;
		for (int i = 0; i < STORE_LEN; i++) rec_buf[i] = 8'd0;
		name_open = 1'b0;
		err_code = ST_OK;
	endtask

	// A finished block either halts on a held error or expects the next header.
	task automatic close_block();
		if (err_code != ST_OK) begin
			stg = STG_HALTED;
		end else begin
			stg = STG_HEADER;
			hdr_cnt = 3'd0;
		end
	endtask

	// Advances the parser model by one byte and queues the records it yields.
	task automatic parse_font_byte(input logic [7:0] b, input logic fin);
		result_t rec;
		result_t found[$];
		status_t st;
		if (b == 8'd0) name_open = 1'b0;
		case (stg)
			STG_SIGNATURE: begin
				if (b != SIG_BYTES[hdr_cnt[1:0]]) begin
					err_code = ST_BAD_SIG;
					stg = STG_HALTED;
				end else begin
					hdr_cnt++;
					if (hdr_cnt >= 3'd4) begin
						hdr_cnt = 3'd0;
						stg = STG_HEADER;
					end
				end
			end
			STG_HEADER: begin
				if (hdr_cnt == 3'd0) begin
					blk_id = b;
					blk_left = 32'd0;
				end else begin
					blk_left |= 32'(b) << (8 * (int'(hdr_cnt) - 1));
				end
				hdr_cnt++;
				if (hdr_cnt >= 3'd5) begin
					hdr_cnt = 3'd0;
					rec_off = 5'd0;
					if (blk_id < BLK_INFO || blk_id > BLK_KERN) err_code = ST_UNKNOWN_BLOCK;
					if (blk_id == BLK_PAGES) name_open = 1'b1;
					if (blk_left == 32'd0) close_block();
					else stg = STG_BODY;
				end
			end
			STG_BODY: begin
				blk_left--;
				if (blk_id == BLK_COMMON && rec_off < COMMON_LEN) begin
					rec_buf[rec_off] = b;
					rec_off++;
					if (rec_off == 5'(COMMON_LEN)) begin
						rec = '0;
						rec.kind = KIND_COMMON;
						rec.x_or_line_height = le16(0);
						rec.y_or_base = le16(2);
						rec.width_or_scale_w = le16(4);
						rec.height_or_scale_h = le16(6);
						rec.page_count = le16(8);
						found.push_back(rec);
						if (le16(8) > 16'd1 && err_code == ST_OK) err_code = ST_TOO_MANY_PAGE;
					end
				end else if (blk_id == BLK_CHARS) begin
					if (rec_off < STORE_LEN) rec_buf[rec_off] = b;
					rec_off++;
					if (rec_off >= 5'(CHAR_LEN)) begin
						rec_off = 5'd0;
						if ({le16(2), le16(0)} < CODE_LIMIT) begin
							rec = '0;
							rec.kind = KIND_GLYPH;
							rec.char_code = rec_buf[0];
							rec.x_or_line_height = le16(4);
							rec.y_or_base = le16(6);
							rec.width_or_scale_w = le16(8);
							rec.height_or_scale_h = le16(10);
							rec.x_offset = le16(12);
							rec.y_offset = le16(14);
							rec.advance = le16(16);
							found.push_back(rec);
						end
					end
				end
				if (blk_left == 32'd0) close_block();
			end
			default: begin
			end
		endcase

		if (!fin) begin
			if (found.size() != 0) found[found.size() - 1].last_result = 1'b1;
		end else begin
			// The status record closes the file; a pending page name usually wins.
			if (stg == STG_SIGNATURE) st = ST_BAD_SIG;
			else if (stg == STG_HALTED) st = name_open ? ST_UNTERMINATED : err_code;
			else if (stg == STG_HEADER) st = name_open ? ST_UNTERMINATED : ST_OK;
			else if (blk_id == BLK_PAGES) st = ST_TRUNCATED;
			else st = name_open ? ST_UNTERMINATED : ST_TRUNCATED;
			rec = '0;
			rec.kind = KIND_STATUS;
			rec.status = st;
			rec.last_result = 1'b1;
			found.push_back(rec);
			clear_parser_model();
		end
		foreach (found[i]) expected_records.push_back(found[i]);
	endtask

	task automatic compare_field(input string label, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
			failed = 1'b1;
		end
	endtask

	// Compares one output transaction with the oldest expected record.
	task automatic check_record();
		result_t want;
		if (expected_records.size() == 0) begin
			$display("%0t: unexpected record, expected none, actual kind %0d status %0d",
				$time, record_kind, status);
			failed = 1'b1;
		end else begin
			want = expected_records.pop_front();
			compare_field("record_kind", want.kind, record_kind);
			compare_field("char_code", want.char_code, char_code);
			compare_field("x_or_line_height", want.x_or_line_height, x_or_line_height);
			compare_field("y_or_base", want.y_or_base, y_or_base);
			compare_field("width_or_scale_w", want.width_or_scale_w, width_or_scale_w);
			compare_field("height_or_scale_h", want.height_or_scale_h, height_or_scale_h);
			compare_field("x_offset", want.x_offset, x_offset);
			compare_field("y_offset", want.y_offset, y_offset);
			compare_field("advance", want.advance, advance);
			compare_field("page_count", want.page_count, page_count);
			compare_field("status", want.status, status);
			compare_field("last_result", want.last_result, last_result);
		end
	endtask

	// Driver: offers queued bytes, idling before each as drawn; a drain byte waits for no expected records.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'd0;
			last_byte <= 1'b0;
			idle_count = 0;
			clear_parser_model();
		end else begin
			if (in_valid && !in_stall) begin
				parse_font_byte(data_byte, last_byte);
			end
			// A stalled transaction stays on the port unchanged.
			if (!(in_valid && in_stall)) begin
				if (pending_bytes.size() == 0) begin
					in_valid <= 1'b0;
				end else if (pending_bytes[0].drain && expected_records.size() != 0) begin
					in_valid <= 1'b0;
				end else if (idle_count < pending_bytes[0].gap) begin
					idle_count++;
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					data_byte <= pending_bytes[0].data;
					last_byte <= pending_bytes[0].fin;
					pending_bytes.pop_front();
					idle_count = 0;
				end
			end
		end
	end

	// Monitor: checks each result and stalls a drawn number of cycles after it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_count = 0;
			hold_count = 0;
			results_checked = 0;
		end else begin
			if (out_valid && !out_stall) begin
				check_record();
				results_checked++;
				stall_count = ((results_checked / 30) % 3 == 1) ? 0 : $urandom_range(0, 14);
				// One long hold lets the output queue fill and back up the input.
				if (results_checked == 40) hold_count = 1200;
			end else if (hold_count > 0) begin
				hold_count--;
			end else if (stall_count > 0) begin
				stall_count--;
			end
			out_stall <= (hold_count > 0) || (stall_count > 0);
		end
	end

	task automatic queue_file(input int gap_max, input bit drain_first);
		byte_item_t item;
		foreach (file_buf[i]) begin
			item.data = file_buf[i];
			item.fin = (i == file_buf.size() - 1);
			item.gap = $urandom_range(0, gap_max);
			item.drain = drain_first && (i == 0);
			pending_bytes.push_back(item);
		end
	endtask

	task automatic put_sig();
		for (int i = 0; i < 4; i++) file_buf.push_back(SIG_BYTES[i]);
	endtask

	task automatic put_header(input logic [7:0] id, input logic [31:0] size);
		file_buf.push_back(id);
		for (int i = 0; i < 4; i++) file_buf.push_back(size[8 * i +: 8]);
	endtask

	task automatic put_random(input int count);
		repeat (count) file_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	// Appends one block: mostly known kinds with plausible content.
	task automatic put_block();
		int pick;
		int size;
		int entries;
		int tail;
		int style;
		logic [7:0] common_body [COMMON_LEN];
		logic [15:0] pages;
		logic [31:0] code;
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			// A size far past any file end.
			put_header(8'($urandom_range(1, 5)), $urandom() | 32'h0100_0000);
			put_random($urandom_range(0, 10));
		end else if (pick < 10) begin
			put_header(($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(6, 255)),
				$urandom_range(0, 6));
			put_random(file_buf.size() == 0 ? 0 : $urandom_range(0, 0));
		end else if (pick < 20) begin
			size = $urandom_range(0, 8);
			put_header(($urandom_range(0, 1) != 0) ? BLK_INFO : BLK_KERN, size);
			put_random(size);
		end else if (pick < 37) begin
			size = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 9) : $urandom_range(10, 13);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: pages = 16'd0;
				4, 5, 6, 7: pages = 16'd1;
				8: pages = 16'd2;
				default: pages = 16'($urandom());
			endcase
			for (int i = 0; i < 8; i++) common_body[i] = 8'($urandom_range(0, 255));
			common_body[8] = pages[7:0];
			common_body[9] = pages[15:8];
			put_header(BLK_COMMON, size);
			for (int i = 0; i < size; i++)
				file_buf.push_back(i < COMMON_LEN ? common_body[i] : 8'($urandom_range(0, 255)));
		end else if (pick < 52) begin
			size = $urandom_range(1, 8);
			put_header(BLK_PAGES, size);
			for (int i = 0; i < size - 1; i++) file_buf.push_back(8'($urandom_range(1, 255)));
			file_buf.push_back(($urandom_range(0, 4) != 0) ? 8'd0 : 8'($urandom_range(1, 255)));
		end else begin
			entries = $urandom_range(1, 2);
			tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
			put_header(BLK_CHARS, entries * CHAR_LEN + tail);
			repeat (entries) begin
				case ($urandom_range(0, 9))
					7: code = $urandom_range(255, 256);
					8: code = $urandom();
					9: code = ($urandom() & 32'hFF) | (32'h1 << $urandom_range(8, 31));
					default: code = $urandom_range(0, 255);
				endcase
				for (int i = 0; i < 4; i++) file_buf.push_back(code[8 * i +: 8]);
				// Glyph fields: random, or the extremes of the 16-bit range.
				style = $urandom_range(0, 5);
				for (int i = 0; i < CHAR_LEN - 4; i++) begin
					case (style)
						1: file_buf.push_back(8'hFF);
						2: file_buf.push_back((i % 2 != 0) ? 8'h80 : 8'h00);
						3: file_buf.push_back((i % 2 != 0) ? 8'h7F : 8'hFF);
						default: file_buf.push_back(8'($urandom_range(0, 255)));
					endcase
				end
			end
			put_random(tail);
		end
	endtask

	// Builds one file: mostly well formed, some noise, cut or padded at the end.
	task automatic build_random_file();
		int shape;
		int cut;
		int idx;
		shape = $urandom_range(0, 99);
		file_buf.delete();
		if (shape < 8) begin
			put_random($urandom_range(1, 12));
		end else begin
			put_sig();
			if (shape < 14) begin
				idx = $urandom_range(0, 3);
				file_buf[idx] = file_buf[idx] ^ (8'd1 << $urandom_range(0, 7));
			end
			repeat ($urandom_range(0, 4)) put_block();
			if (shape < 30) begin
				cut = $urandom_range(1, file_buf.size());
				while (file_buf.size() > cut) void'(file_buf.pop_back());
			end else if (shape < 40) begin
				put_random($urandom_range(1, 4));
			end
		end
	endtask

	// Stimulus, reset and the end of the run.
	initial begin
		int file_count;
		int gap_max;
		// Directed files: a lone bad byte, a cut signature, a cut header,
		// an unknown block id and a page block whose name never ends.
		file_buf = '{8'hFF};
		queue_file(0, 1'b0);
		file_buf = '{8'h42, 8'h4D};
		queue_file(0, 1'b0);
		file_buf.delete();
		put_sig();
		file_buf.push_back(8'h09);
		file_buf.push_back(8'hFF);
		queue_file(0, 1'b0);
		file_buf.delete();
		put_sig();
		put_header(8'd0, 32'd0);
		queue_file(0, 1'b0);
		file_buf.delete();
		put_sig();
		put_header(BLK_PAGES, 32'd0);
		queue_file(0, 1'b0);

		// Random files, with the sender's idling changing from file to file.
		file_count = 0;
		while (pending_bytes.size() < 1930) begin
			build_random_file();
			case (file_count % 4)
				1: gap_max = 0;
				2: gap_max = 4;
				default: gap_max = 14;
			endcase
			queue_file(gap_max, file_count % 7 == 3);
			file_count++;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
		while (expected_records.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (!failed) begin
			$display("** bitmap_font_binary_parser: PASSED **");
		end else begin
			$display("** bitmap_font_binary_parser: FAILED **");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#10000000;
		$display("** bitmap_font_binary_parser: FAILED **");
		$finish;
	end

endmodule
